### rtl/slmp_pkg.sv
// ----------------------------------------------------------------------------
// slmp_pkg
// Types and constants shared by the simulation link message parser.
// ----------------------------------------------------------------------------
package slmp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  field_id;
		logic [63:0] field_value;
		logic [2:0]  error_code;
		logic        message_done;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  version_major;
		logic [7:0]  version_minor;
		logic [7:0]  version_patch;
		logic [15:0] max_pdu_length;
	} cfg_t;

	typedef enum logic [14:0] {
		PH_MARKER   = 15'h0001,
		PH_VERSION  = 15'h0002,
		PH_TYPE     = 15'h0004,
		PH_STI      = 15'h0008,
		PH_SENDER   = 15'h0010,
		PH_SENDER2  = 15'h0020,
		PH_POS      = 15'h0040,
		PH_DBM      = 15'h0080,
		PH_PDUTYPE  = 15'h0100,
		PH_PDUID    = 15'h0200,
		PH_PAYLOAD  = 15'h0400,
		PH_LENGTH   = 15'h0800,
		PH_PDUBYTES = 15'h1000,
		PH_ACKCOUNT = 15'h2000,
		PH_ACKID    = 15'h4000
	} phase_t;

	localparam logic [1:0] CFG_VERSION_MAJOR  = 2'd0;
	localparam logic [1:0] CFG_VERSION_MINOR  = 2'd1;
	localparam logic [1:0] CFG_VERSION_PATCH  = 2'd2;
	localparam logic [1:0] CFG_MAX_PDU_LENGTH = 2'd3;

	localparam logic [7:0]  RST_VERSION_MAJOR  = 8'd3;
	localparam logic [7:0]  RST_VERSION_MINOR  = 8'd2;
	localparam logic [7:0]  RST_VERSION_PATCH  = 8'd7;
	localparam logic [15:0] RST_MAX_PDU_LENGTH = 16'd16384;

	localparam logic [7:0] MARKER_BYTE = 8'd3;

	localparam logic [2:0] KIND_HEARTBEAT = 3'd4;
	localparam logic [2:0] KIND_HB_ACK    = 3'd5;
	localparam logic [2:0] KIND_PDU       = 3'd6;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MARKER    = 3'd1;
	localparam logic [2:0] ERR_VERSION   = 3'd2;
	localparam logic [2:0] ERR_TYPE      = 3'd3;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;

	localparam logic [3:0] FID_TYPE     = 4'd0;
	localparam logic [3:0] FID_STI      = 4'd1;
	localparam logic [3:0] FID_SENDER   = 4'd2;
	localparam logic [3:0] FID_SENDER2  = 4'd3;
	localparam logic [3:0] FID_POS      = 4'd4;
	localparam logic [3:0] FID_DBM      = 4'd7;
	localparam logic [3:0] FID_PDUTYPE  = 4'd8;
	localparam logic [3:0] FID_PDUID    = 4'd9;
	localparam logic [3:0] FID_PAYLOAD  = 4'd10;
	localparam logic [3:0] FID_LENGTH   = 4'd11;
	localparam logic [3:0] FID_PDUBYTE  = 4'd12;
	localparam logic [3:0] FID_ACKCOUNT = 4'd13;
	localparam logic [3:0] FID_ACKID    = 4'd14;

	function automatic logic [3:0] phase_size(input phase_t ph);
		logic [3:0] sz;
		case (ph)
			PH_STI, PH_POS: sz = 4'd8;
			PH_SENDER, PH_SENDER2, PH_DBM, PH_PDUID, PH_PAYLOAD,
			PH_LENGTH, PH_ACKCOUNT, PH_ACKID: sz = 4'd4;
			default: sz = 4'd1;
		endcase
		return sz;
	endfunction

endpackage

### rtl/slmp_core.sv
// ----------------------------------------------------------------------------
// slmp_core
// Parse state and per-byte next-state/result logic. State advances on step.
// ----------------------------------------------------------------------------
module slmp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  slmp_pkg::in_item_t item,
	input  slmp_pkg::cfg_t     cfg,
	output logic               res_valid,
	output slmp_pkg::out_item_t res
);

	slmp_pkg::phase_t phase_q, phase_n;
	logic [2:0]  idx_q, idx_n;
	logic [63:0] acc_q, acc_n;
	logic [31:0] items_q, items_n;
	logic [2:0]  kind_q, kind_n;
	logic        skip_q, skip_n;

	logic [63:0] acc_sh;
	logic [3:0]  cnt;
	logic [2:0]  err;
	logic [3:0]  fid;
	logic        emit;
	logic        done;
	logic [7:0]  want;
	logic        finish;

	always_comb begin
		phase_n   = phase_q;
		idx_n     = idx_q;
		acc_n     = acc_q;
		items_n   = items_q;
		kind_n    = kind_q;
		skip_n    = skip_q;
		res_valid = 1'b0;
		res       = '0;
		acc_sh    = {acc_q[55:0], item.data_byte};
		cnt       = {1'b0, idx_q} + 4'd1;
		err       = slmp_pkg::ERR_NONE;
		fid       = slmp_pkg::FID_TYPE;
		emit      = 1'b0;
		done      = 1'b0;
		want      = cfg.version_patch;
		finish    = 1'b0;
		if (skip_q) begin
			if (item.last_byte) begin
				skip_n = 1'b0;
				finish = 1'b1;
			end
		end else if (cnt < slmp_pkg::phase_size(phase_q)) begin
			acc_n = acc_sh;
			idx_n = cnt[2:0];
			if (item.last_byte) begin
				finish           = 1'b1;
				res_valid        = 1'b1;
				res.error_code   = slmp_pkg::ERR_TRUNCATED;
				res.message_done = 1'b1;
			end
		end else begin
			acc_n = '0;
			idx_n = '0;
			case (phase_q)
				slmp_pkg::PH_VERSION: begin
					if (items_q[1:0] == 2'd0) begin
						want = cfg.version_major;
					end else if (items_q[1:0] == 2'd1) begin
						want = cfg.version_minor;
					end
					if (acc_sh[7:0] != want) begin
						err = slmp_pkg::ERR_VERSION;
					end else if (items_q[1:0] >= 2'd2) begin
						items_n = '0;
						phase_n = slmp_pkg::PH_TYPE;
					end else begin
						items_n = {30'd0, items_q[1:0]} + 32'd1;
					end
				end
				slmp_pkg::PH_TYPE: begin
					if (acc_sh[7:3] != 5'd0 || !acc_sh[2]) begin
						err = slmp_pkg::ERR_TYPE;
					end else begin
						kind_n  = acc_sh[2:0];
						emit    = 1'b1;
						fid     = slmp_pkg::FID_TYPE;
						phase_n = slmp_pkg::PH_STI;
					end
				end
				slmp_pkg::PH_STI: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_STI;
					phase_n = slmp_pkg::PH_SENDER;
				end
				slmp_pkg::PH_SENDER: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_SENDER;
					phase_n = slmp_pkg::PH_SENDER2;
				end
				slmp_pkg::PH_SENDER2: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_SENDER2;
					items_n = '0;
					if (kind_q == slmp_pkg::KIND_HEARTBEAT) begin
						phase_n = slmp_pkg::PH_POS;
					end else if (kind_q == slmp_pkg::KIND_HB_ACK) begin
						phase_n = slmp_pkg::PH_DBM;
					end else if (kind_q == slmp_pkg::KIND_PDU) begin
						phase_n = slmp_pkg::PH_PDUTYPE;
					end else begin
						phase_n = slmp_pkg::PH_ACKCOUNT;
					end
				end
				slmp_pkg::PH_POS: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_POS + {2'd0, items_q[1:0]};
					items_n = items_q + 32'd1;
					done    = (items_q >= 32'd2);
				end
				slmp_pkg::PH_DBM: begin
					emit = 1'b1;
					fid  = slmp_pkg::FID_DBM;
					done = 1'b1;
				end
				slmp_pkg::PH_PDUTYPE: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_PDUTYPE;
					phase_n = slmp_pkg::PH_PDUID;
				end
				slmp_pkg::PH_PDUID: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_PDUID;
					phase_n = slmp_pkg::PH_PAYLOAD;
				end
				slmp_pkg::PH_PAYLOAD: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_PAYLOAD;
					phase_n = slmp_pkg::PH_LENGTH;
				end
				slmp_pkg::PH_LENGTH: begin
					if (acc_sh[31:16] != 16'd0 || acc_sh[15:0] > cfg.max_pdu_length) begin
						err = slmp_pkg::ERR_TOO_LONG;
					end else begin
						emit    = 1'b1;
						fid     = slmp_pkg::FID_LENGTH;
						items_n = acc_sh[31:0];
						if (acc_sh[15:0] == 16'd0) begin
							done = 1'b1;
						end else begin
							phase_n = slmp_pkg::PH_PDUBYTES;
						end
					end
				end
				slmp_pkg::PH_PDUBYTES: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_PDUBYTE;
					items_n = items_q - 32'd1;
					done    = (items_q == 32'd1);
				end
				slmp_pkg::PH_ACKCOUNT: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_ACKCOUNT;
					items_n = acc_sh[31:0];
					if (acc_sh[31:0] == 32'd0) begin
						done = 1'b1;
					end else begin
						phase_n = slmp_pkg::PH_ACKID;
					end
				end
				slmp_pkg::PH_ACKID: begin
					emit    = 1'b1;
					fid     = slmp_pkg::FID_ACKID;
					items_n = items_q - 32'd1;
					done    = (items_q == 32'd1);
				end
				default: begin
					if (acc_sh[7:0] != slmp_pkg::MARKER_BYTE) begin
						err = slmp_pkg::ERR_MARKER;
					end else begin
						phase_n = slmp_pkg::PH_VERSION;
						items_n = '0;
					end
				end
			endcase

			if (err != slmp_pkg::ERR_NONE) begin
				finish           = 1'b1;
				skip_n           = !item.last_byte;
				res_valid        = 1'b1;
				res.error_code   = err;
				res.message_done = 1'b1;
			end else if (done) begin
				finish           = 1'b1;
				skip_n           = !item.last_byte;
				res_valid        = 1'b1;
				res.field_id     = fid;
				res.field_value  = acc_sh;
				res.message_done = 1'b1;
			end else if (item.last_byte) begin
				finish           = 1'b1;
				res_valid        = 1'b1;
				res.error_code   = slmp_pkg::ERR_TRUNCATED;
				res.message_done = 1'b1;
			end else if (emit) begin
				res_valid       = 1'b1;
				res.field_id    = fid;
				res.field_value = acc_sh;
			end
		end

		if (finish) begin
			phase_n = slmp_pkg::PH_MARKER;
			idx_n   = '0;
			acc_n   = '0;
			items_n = '0;
			kind_n  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= slmp_pkg::PH_MARKER;
			idx_q   <= '0;
			acc_q   <= '0;
			items_q <= '0;
			kind_q  <= '0;
			skip_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			acc_q   <= acc_n;
			items_q <= items_n;
			kind_q  <= kind_n;
			skip_q  <= skip_n;
		end
	end

endmodule

### rtl/sim_link_message_parser.sv
// ----------------------------------------------------------------------------
// sim_link_message_parser
// Byte-serial parser for simulation link datagrams.
//
// Input channel: one datagram byte per transaction, last_byte on the final
// byte. Output channel: one transaction per completed field from the type
// field on, error or truncation; message_done marks the transaction that ends
// a message. Marker and version bytes, bytes that complete no field and
// trailing bytes after an error or a finished message give no output.
// Each byte is held in the byte register, its result in the output register;
// each holds one transaction. Throughput: one byte per cycle while the
// receiver takes results. When the receiver stalls with a result waiting, at
// most one more byte is taken into the byte register and then in_stall rises
// until the output moves. Reset clears the parse state and loads the default
// version 3.2.7 and a maximum PDU length of 16384. Configuration writes are
// for the user to make while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module sim_link_message_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  slmp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output slmp_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	slmp_pkg::cfg_t      cfg_q;
	slmp_pkg::in_item_t  item_s1;
	logic                valid_s1;
	slmp_pkg::out_item_t out_q;
	logic                out_valid_q;

	logic                out_free;
	logic                step;
	logic                res_valid;
	slmp_pkg::out_item_t res;

	assign out_free  = !out_valid_q || !out_stall;
	assign step      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	slmp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.version_major  <= slmp_pkg::RST_VERSION_MAJOR;
			cfg_q.version_minor  <= slmp_pkg::RST_VERSION_MINOR;
			cfg_q.version_patch  <= slmp_pkg::RST_VERSION_PATCH;
			cfg_q.max_pdu_length <= slmp_pkg::RST_MAX_PDU_LENGTH;
		end else if (cfg_we) begin
			case (cfg_index)
				slmp_pkg::CFG_VERSION_MAJOR:  cfg_q.version_major  <= cfg_data[7:0];
				slmp_pkg::CFG_VERSION_MINOR:  cfg_q.version_minor  <= cfg_data[7:0];
				slmp_pkg::CFG_VERSION_PATCH:  cfg_q.version_patch  <= cfg_data[7:0];
				slmp_pkg::CFG_MAX_PDU_LENGTH: cfg_q.max_pdu_length <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (step) begin
				valid_s1 <= 1'b0;
			end
			if (step && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (step && res_valid) begin
			out_q <= res;
		end
	end

endmodule

### dv/sim_link_message_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sim_link_message_parser_tb
// Self-checking bench for the byte-serial link message parser. A queue of
// datagrams (directed corner cases, then random well-formed and corrupted
// traffic under several version/length settings) feeds a clocked driver; a
// clocked monitor compares every output transaction with a local parser
// that tracks the field state byte by byte. Both sides idle in random bursts
// save in the last run, and the receiver once holds off to back up the input.
// ----------------------------------------------------------------------------
module sim_link_message_parser_tb;

	localparam logic [2:0] KIND_PDU_ACK = 3'd7;
	localparam logic [3:0] FID_NONE     = 4'd0;
	localparam int         STALL_LIMIT  = 5000;
	localparam int         HOLD_CYCLES  = 300;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	slmp_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	slmp_pkg::out_item_t out_data;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = slmp_pkg::CFG_VERSION_MAJOR;
	logic [15:0]         cfg_data = '0;

	sim_link_message_parser dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// configuration as the bench believes it to be
	logic [7:0]  want_major   = slmp_pkg::RST_VERSION_MAJOR;
	logic [7:0]  want_minor   = slmp_pkg::RST_VERSION_MINOR;
	logic [7:0]  want_patch   = slmp_pkg::RST_VERSION_PATCH;
	logic [15:0] want_max_len = slmp_pkg::RST_MAX_PDU_LENGTH;

	// parser state tracked by the bench
	slmp_pkg::phase_t cur_phase  = slmp_pkg::PH_MARKER;
	logic [2:0]       byte_idx   = '0;
	logic [63:0]      field_acc  = '0;
	logic [31:0]      items_left = '0;
	logic [2:0]       msg_kind   = '0;
	logic             skip_rest  = 1'b0;

	slmp_pkg::in_item_t  byte_queue[$];
	slmp_pkg::out_item_t pending_fields[$];
	logic [7:0]          msg_bytes[$];
	int          bytes_queued  = 0;
	int          error_count   = 0;
	int          hold_requests = 0;
	int          hold_served   = 0;
	int          hold_left     = 0;
	int          tx_gap        = 0;
	int          rx_gap        = 0;
	int          idle_cycles   = 0;
	logic        no_idle       = 1'b0;

	function automatic void restart_message();
		cur_phase  = slmp_pkg::PH_MARKER;
		byte_idx   = '0;
		field_acc  = '0;
		items_left = '0;
		msg_kind   = '0;
	endfunction

	function automatic void push_field(input logic [3:0] fid, input logic [63:0] val,
			input logic [2:0] err, input logic done);
		slmp_pkg::out_item_t r;
		r.field_id     = fid;
		r.field_value  = val;
		r.error_code   = err;
		r.message_done = done;
		pending_fields = {pending_fields, r};
	endfunction

	function automatic void parse_byte(input slmp_pkg::in_item_t it);
		logic [63:0] v;
		logic [3:0]  cnt;
		logic [3:0]  sz;
		logic [7:0]  want;
		logic [3:0]  fid;
		logic [2:0]  err;
		logic        emit;
		logic        done;
		err  = slmp_pkg::ERR_NONE;
		fid  = FID_NONE;
		emit = 1'b0;
		done = 1'b0;
		if (skip_rest) begin
			if (it.last_byte) begin
				skip_rest = 1'b0;
				restart_message();
			end
			return;
		end
		field_acc = {field_acc[55:0], it.data_byte};
		cnt = {1'b0, byte_idx} + 4'd1;
		case (cur_phase)
			slmp_pkg::PH_STI, slmp_pkg::PH_POS: sz = 4'd8;
			slmp_pkg::PH_SENDER, slmp_pkg::PH_SENDER2, slmp_pkg::PH_DBM,
			slmp_pkg::PH_PDUID, slmp_pkg::PH_PAYLOAD, slmp_pkg::PH_LENGTH,
			slmp_pkg::PH_ACKCOUNT, slmp_pkg::PH_ACKID: sz = 4'd4;
			default: sz = 4'd1;
		endcase
		if (cnt < sz) begin
			byte_idx = cnt[2:0];
			if (it.last_byte) begin
				restart_message();
				push_field(FID_NONE, '0, slmp_pkg::ERR_TRUNCATED, 1'b1);
			end
			return;
		end
		v = field_acc;
		field_acc = '0;
		byte_idx = '0;
		case (cur_phase)
			slmp_pkg::PH_VERSION: begin
				case (items_left[1:0])
					2'd0: want = want_major;
					2'd1: want = want_minor;
					default: want = want_patch;
				endcase
				if (v != {56'd0, want}) begin
					err = slmp_pkg::ERR_VERSION;
				end else begin
					items_left = {30'd0, items_left[1:0]} + 32'd1;
					if (items_left >= 32'd3) begin
						items_left = '0;
						cur_phase = slmp_pkg::PH_TYPE;
					end
				end
			end
			slmp_pkg::PH_TYPE: begin
				if (v < 64'd4 || v > 64'd7) begin
					err = slmp_pkg::ERR_TYPE;
				end else begin
					msg_kind = v[2:0];
					emit = 1'b1;
					fid = slmp_pkg::FID_TYPE;
					cur_phase = slmp_pkg::PH_STI;
				end
			end
			slmp_pkg::PH_STI: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_STI;
				cur_phase = slmp_pkg::PH_SENDER;
			end
			slmp_pkg::PH_SENDER: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_SENDER;
				cur_phase = slmp_pkg::PH_SENDER2;
			end
			slmp_pkg::PH_SENDER2: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_SENDER2;
				items_left = '0;
				if (msg_kind == slmp_pkg::KIND_HEARTBEAT) cur_phase = slmp_pkg::PH_POS;
				else if (msg_kind == slmp_pkg::KIND_HB_ACK) cur_phase = slmp_pkg::PH_DBM;
				else if (msg_kind == slmp_pkg::KIND_PDU) cur_phase = slmp_pkg::PH_PDUTYPE;
				else cur_phase = slmp_pkg::PH_ACKCOUNT;
			end
			slmp_pkg::PH_POS: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_POS + {2'b00, items_left[1:0]};
				items_left = items_left + 32'd1;
				if (items_left >= 32'd3) done = 1'b1;
			end
			slmp_pkg::PH_DBM: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_DBM;
				done = 1'b1;
			end
			slmp_pkg::PH_PDUTYPE: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_PDUTYPE;
				cur_phase = slmp_pkg::PH_PDUID;
			end
			slmp_pkg::PH_PDUID: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_PDUID;
				cur_phase = slmp_pkg::PH_PAYLOAD;
			end
			slmp_pkg::PH_PAYLOAD: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_PAYLOAD;
				cur_phase = slmp_pkg::PH_LENGTH;
			end
			slmp_pkg::PH_LENGTH: begin
				if (v[31] || v > {48'd0, want_max_len}) begin
					err = slmp_pkg::ERR_TOO_LONG;
				end else begin
					emit = 1'b1;
					fid = slmp_pkg::FID_LENGTH;
					items_left = v[31:0];
					if (items_left == '0) done = 1'b1;
					else cur_phase = slmp_pkg::PH_PDUBYTES;
				end
			end
			slmp_pkg::PH_PDUBYTES: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_PDUBYTE;
				items_left = items_left - 32'd1;
				if (items_left == '0) done = 1'b1;
			end
			slmp_pkg::PH_ACKCOUNT: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_ACKCOUNT;
				items_left = v[31:0];
				if (items_left == '0) done = 1'b1;
				else cur_phase = slmp_pkg::PH_ACKID;
			end
			slmp_pkg::PH_ACKID: begin
				emit = 1'b1;
				fid = slmp_pkg::FID_ACKID;
				items_left = items_left - 32'd1;
				if (items_left == '0) done = 1'b1;
			end
			default: begin
				if (v != {56'd0, slmp_pkg::MARKER_BYTE}) begin
					err = slmp_pkg::ERR_MARKER;
				end else begin
					cur_phase = slmp_pkg::PH_VERSION;
					items_left = '0;
				end
			end
		endcase
		if (err != slmp_pkg::ERR_NONE) begin
			restart_message();
			skip_rest = !it.last_byte;
			push_field(FID_NONE, '0, err, 1'b1);
		end else if (done) begin
			restart_message();
			skip_rest = !it.last_byte;
			push_field(fid, v, slmp_pkg::ERR_NONE, 1'b1);
		end else if (it.last_byte) begin
			restart_message();
			push_field(FID_NONE, '0, slmp_pkg::ERR_TRUNCATED, 1'b1);
		end else if (emit) begin
			push_field(fid, v, slmp_pkg::ERR_NONE, 1'b0);
		end
	endfunction

	// ------------------------------------------------------------------
	// datagram construction
	// ------------------------------------------------------------------
	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic void add_byte(input logic [7:0] b);
		msg_bytes = {msg_bytes, b};
	endfunction

	function automatic void put_be(input logic [63:0] v, input int n);
		for (int i = n - 1; i >= 0; i--)
			add_byte(v[8*i +: 8]);
	endfunction

	function automatic void build_message(input logic [2:0] kind, input logic [31:0] count,
			input int nitems);
		msg_bytes.delete();
		add_byte(slmp_pkg::MARKER_BYTE);
		add_byte(want_major);
		add_byte(want_minor);
		add_byte(want_patch);
		add_byte({5'd0, kind});
		put_be(pick64(), 8);
		put_be(pick64(), 4);
		put_be(pick64(), 4);
		case (kind)
			slmp_pkg::KIND_HEARTBEAT: repeat (3) put_be(pick64(), 8);
			slmp_pkg::KIND_HB_ACK: put_be(pick64(), 4);
			slmp_pkg::KIND_PDU: begin
				put_be(pick64(), 1);
				put_be(pick64(), 4);
				put_be(pick64(), 4);
				put_be({32'd0, count}, 4);
				repeat (nitems) put_be(pick64(), 1);
			end
			default: begin
				put_be({32'd0, count}, 4);
				repeat (nitems) put_be(pick64(), 4);
			end
		endcase
	endfunction

	// cut > 0 ends the datagram after that many bytes; extra appends trailing bytes
	function automatic void queue_datagram(input int cut, input int extra);
		slmp_pkg::in_item_t it;
		if (cut > 0)
			while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
		repeat (extra) add_byte(8'($urandom));
		foreach (msg_bytes[i]) begin
			it.data_byte = msg_bytes[i];
			it.last_byte = (i == msg_bytes.size() - 1);
			byte_queue = {byte_queue, it};
		end
		bytes_queued += msg_bytes.size();
	endfunction

	function automatic void queue_traffic(input int nbytes);
		int          stop_at;
		int          nitems;
		int          r;
		int          k;
		logic [2:0]  kind;
		logic [31:0] count;
		logic [7:0]  t;
		stop_at = bytes_queued + nbytes;
		while (bytes_queued < stop_at) begin
			kind = 3'($urandom_range(4, 7));
			count = '0;
			nitems = 0;
			if (kind == slmp_pkg::KIND_PDU) begin
				case ($urandom_range(0, 9))
					0: count = {16'd0, want_max_len} + 32'd1;
					1: count = {1'b1, 31'($urandom)};
					2: begin
						count = {16'd0, want_max_len};
						nitems = (want_max_len <= 16'd40) ? int'(want_max_len) : 3;
					end
					default: begin
						count = $urandom_range(0, (want_max_len < 16'd8) ? want_max_len : 8);
						nitems = count;
					end
				endcase
			end else if (kind == KIND_PDU_ACK) begin
				if ($urandom_range(0, 9) == 0) begin
					count = $urandom;
					nitems = 2;
				end else begin
					count = $urandom_range(0, 5);
					nitems = count;
				end
			end
			build_message(kind, count, nitems);
			r = $urandom_range(0, 99);
			if (r < 70) begin
				queue_datagram(0, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
			end else if (r < 80) begin
				queue_datagram($urandom_range(1, msg_bytes.size() - 1), 0);
			end else if (r < 85) begin
				msg_bytes[0] ^= 8'($urandom_range(1, 255));
				queue_datagram(($urandom_range(0, 3) == 0) ? 1 : 0, 0);
			end else if (r < 90) begin
				k = $urandom_range(1, 3);
				msg_bytes[k] ^= 8'($urandom_range(1, 255));
				queue_datagram(($urandom_range(0, 3) == 0) ? k + 1 : 0, 0);
			end else if (r < 95) begin
				t = 8'($urandom_range(0, 251));
				if (t >= 8'd4) t = t + 8'd4;
				msg_bytes[4] = t;
				queue_datagram(0, 0);
			end else begin
				msg_bytes.delete();
				repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
				queue_datagram(0, 0);
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// configuration and sequencing
	// ------------------------------------------------------------------
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			slmp_pkg::CFG_VERSION_MAJOR: want_major = val[7:0];
			slmp_pkg::CFG_VERSION_MINOR: want_minor = val[7:0];
			slmp_pkg::CFG_VERSION_PATCH: want_patch = val[7:0];
			default: want_max_len = val;
		endcase
	endtask

	task automatic set_config(input logic [7:0] major, input logic [7:0] minor,
			input logic [7:0] patch, input logic [15:0] max_len);
		write_reg(slmp_pkg::CFG_VERSION_MAJOR, {8'd0, major});
		write_reg(slmp_pkg::CFG_VERSION_MINOR, {8'd0, minor});
		write_reg(slmp_pkg::CFG_VERSION_PATCH, {8'd0, patch});
		write_reg(slmp_pkg::CFG_MAX_PDU_LENGTH, max_len);
	endtask

	task automatic wait_idle();
		while (byte_queue.size() != 0 || in_valid || pending_fields.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// marker errors, alone and followed by the rest of a datagram
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		msg_bytes[0] = 8'h00;
		queue_datagram(1, 0);
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		msg_bytes[0] = 8'hFF;
		queue_datagram(0, 0);
		// good marker as the only byte
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		queue_datagram(1, 0);
		// version mismatch on each byte, and on the final byte
		for (int k = 1; k <= 3; k++) begin
			build_message(slmp_pkg::KIND_HB_ACK, 0, 0);
			msg_bytes[k] ^= 8'h80;
			queue_datagram(0, 0);
		end
		build_message(slmp_pkg::KIND_HB_ACK, 0, 0);
		msg_bytes[1] ^= 8'h01;
		queue_datagram(2, 0);
		// unknown types
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		msg_bytes[4] = 8'h00;
		queue_datagram(0, 0);
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		msg_bytes[4] = 8'hFF;
		queue_datagram(0, 0);
		// every message type complete
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		queue_datagram(0, 0);
		build_message(slmp_pkg::KIND_HB_ACK, 0, 0);
		queue_datagram(0, 0);
		build_message(slmp_pkg::KIND_PDU, 0, 0);
		queue_datagram(0, 0);
		build_message(slmp_pkg::KIND_PDU, 3, 3);
		queue_datagram(0, 0);
		build_message(KIND_PDU_ACK, 0, 0);
		queue_datagram(0, 0);
		build_message(KIND_PDU_ACK, 3, 3);
		queue_datagram(0, 0);
		// length limit edges
		build_message(slmp_pkg::KIND_PDU, {16'd0, want_max_len}, 2);
		queue_datagram(0, 0);
		build_message(slmp_pkg::KIND_PDU, {16'd0, want_max_len} + 32'd1, 0);
		queue_datagram(0, 0);
		build_message(slmp_pkg::KIND_PDU, 32'h8000_0000, 0);
		queue_datagram(0, 2);
		build_message(slmp_pkg::KIND_PDU, 32'hFFFF_FFFF, 0);
		queue_datagram(0, 0);
		// trailing bytes after a complete message, truncation mid-field and on a field end
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		queue_datagram(0, 3);
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		queue_datagram(8, 0);
		build_message(slmp_pkg::KIND_HEARTBEAT, 0, 0);
		queue_datagram(21, 0);
		wait_idle();

		set_config(8'h00, 8'h00, 8'h00, 16'd0);
		queue_traffic(350);
		wait_idle();

		set_config(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		queue_traffic(350);
		hold_requests++;
		wait_idle();

		set_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(1, 40)));
		queue_traffic(350);
		wait_idle();

		no_idle = 1'b1;
		set_config(slmp_pkg::RST_VERSION_MAJOR, slmp_pkg::RST_VERSION_MINOR,
			slmp_pkg::RST_VERSION_PATCH, slmp_pkg::RST_MAX_PDU_LENGTH);
		queue_traffic(350);
		wait_idle();

		if (error_count == 0)
			$display("sim_link_message_parser_tb: PASS");
		else
			$display("sim_link_message_parser_tb: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		slmp_pkg::in_item_t nxt_data;
		logic               nxt_valid;
		if (arst_n) begin
			nxt_valid = in_valid;
			nxt_data  = in_data;
			if (in_valid && !in_stall) begin
				parse_byte(in_data);
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (byte_queue.size() != 0) begin
					nxt_data  = byte_queue.pop_front();
					nxt_valid = 1'b1;
					if (!no_idle && $urandom_range(0, 7) == 0)
						tx_gap = $urandom_range(1, 5);
				end
			end
			in_valid <= nxt_valid;
			in_data  <= nxt_data;
		end
	end

	// ------------------------------------------------------------------
	// monitor
	// ------------------------------------------------------------------
	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		slmp_pkg::out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_fields.size() == 0) begin
					$display("%0t: unexpected transaction: expected none, got id %0d val %h err %0d done %b",
						$time, out_data.field_id, out_data.field_value,
						out_data.error_code, out_data.message_done);
					error_count++;
				end else begin
					want = pending_fields.pop_front();
					compare_field("field_id", 64'(want.field_id), 64'(out_data.field_id));
					compare_field("field_value", want.field_value, out_data.field_value);
					compare_field("error_code", 64'(want.error_code),
						64'(out_data.error_code));
					compare_field("message_done", 64'(want.message_done),
						64'(out_data.message_done));
				end
			end
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				if (!no_idle && $urandom_range(0, 5) == 0)
					rx_gap = $urandom_range(1, 5);
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("sim_link_message_parser_tb: FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

endmodule

### filelist.f
rtl/slmp_pkg.sv
rtl/slmp_core.sv
rtl/sim_link_message_parser.sv
dv/sim_link_message_parser_tb.sv
